// ===== src/lpad_pkg.sv =====
// Shared constants, types and functions for the lattice potential action delta block.
// Holds the quarter-wave sine table, built at elaboration, and the 48-bit saturation.
// No dependencies.
package lpad_pkg;

	localparam int AXES             = 3;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int LANES            = 2 * AXES;

	localparam int COORD_W    = 16;
	localparam int MAG_W      = COORD_W + 1;
	localparam int PHASE_W    = 16;
	localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SINE_W     = 15;
	localparam int SQ_W       = 31;
	localparam int POT_W      = 32;
	localparam int DIFF_W     = 34;
	localparam int PROD_W     = DIFF_W + 17;
	localparam int ACT_W      = 48;
	localparam int SUM_W      = 53;
	localparam int TS_W       = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS_DEPTHS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_WAVENUMBERS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_CUTOFFS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE       = 3'd3;

	localparam logic [TS_W-1:0] TIME_SCALE_RESET = 32'h0001_0000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned TAYLOR_DIV [5] = '{6, 20, 42, 72, 110};

	typedef struct packed {
		logic signed [COORD_W-1:0] depth;
		logic [COORD_W-1:0]        wavenumber;
		logic [COORD_W-1:0]        cutoff;
	} lane_cfg_t;

	typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	// Q0.15 sine magnitude at idx * (pi/2) / depth, odd Taylor series in Q30.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] q;
		if (idx >= SINE_TABLE_DEPTH) begin
			return {SINE_W{1'b1}};
		end
		x    = (64'(idx) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
		term = x;
		sum  = signed'(x);
		for (int k = 1; k <= 5; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'(TAYLOR_DIV[k-1]);
			if (k % 2 == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (sum + 64'sd16384) >>> 15;
		if (q > 64'sd32767) begin
			return {SINE_W{1'b1}};
		end
		return SINE_W'(q);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			rom[i] = sine_entry(i);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Clamp a wide signed sum to the 48-bit action range.
	function automatic logic signed [ACT_W-1:0] sat_act(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (v[SUM_W-1:ACT_W-1] == '0) || (v[SUM_W-1:ACT_W-1] == '1);
		if (fits) begin
			return v[ACT_W-1:0];
		end
		return v[SUM_W-1] ? {1'b1, {(ACT_W-1){1'b0}}} : {1'b0, {(ACT_W-1){1'b1}}};
	endfunction

endpackage

// ===== src/lpad_if.sv =====
// Channel interfaces of the lattice potential action delta block: bead pairs in,
// action results out, register writes. Depends on lpad_pkg.
interface lpad_in_if;
	import lpad_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] new_x;
	logic signed [COORD_W-1:0] new_y;
	logic signed [COORD_W-1:0] new_z;
	logic signed [COORD_W-1:0] old_x;
	logic signed [COORD_W-1:0] old_y;
	logic signed [COORD_W-1:0] old_z;
	logic                      final_pair;

	modport source(output valid, new_x, new_y, new_z, old_x, old_y, old_z, final_pair,
		input ready);
	modport sink(input valid, new_x, new_y, new_z, old_x, old_y, old_z, final_pair,
		output ready);
endinterface

interface lpad_out_if;
	import lpad_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ACT_W-1:0] pair_delta;
	logic signed [ACT_W-1:0] running_total;
	logic                    is_last;

	modport source(output valid, pair_delta, running_total, is_last, input ready);
	modport sink(input valid, pair_delta, running_total, is_last, output ready);
endinterface

interface lpad_cfg_if;
	import lpad_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/lpad_lane.sv =====
// One coordinate lane: magnitude, phase, quarter-wave sine lookup, sin^2 and
// the axis potential over four pipeline stages. Depends on lpad_pkg.
module lpad_lane (
	input  logic                              clk,
	input  logic                              en,
	input  lpad_pkg::lane_cfg_t               lane_cfg,
	input  logic signed [lpad_pkg::COORD_W-1:0] coord,
	output logic signed [lpad_pkg::POT_W-1:0]   pot
);
	import lpad_pkg::*;

	localparam int SCALE_W = 14 + IDX_W;
	localparam int PPROD_W = MAG_W + COORD_W;
	localparam int DPROD_W = SQ_W + COORD_W;
	localparam logic signed [SQ_W-1:0] SQ_HALF = SQ_W'(1) <<< 29;

	logic signed [MAG_W-1:0] coord_ext;
	logic [MAG_W-1:0]        mag;
	logic [PPROD_W-1:0]      phase_prod;
	logic [SCALE_W-1:0]      idx_scaled;
	logic [IDX_W-1:0]        idx_raw;
	logic [IDX_W-1:0]        idx;
	logic signed [DPROD_W-1:0] depth_prod;
	logic signed [DPROD_W-1:0] depth_shift;
	logic [MAG_W-1:0]        depth_mag;
	logic signed [POT_W-1:0] beyond_pot;

	logic [PHASE_W-1:0]      phase_s1;
	logic                    inside_s1;
	logic [SINE_W-1:0]       sine_s2;
	logic                    inside_s2;
	logic signed [SQ_W-1:0]  sq_s3;
	logic                    inside_s3;
	logic signed [POT_W-1:0] pot_s4;

	always_comb begin
		coord_ext  = MAG_W'(coord);
		mag        = coord_ext[MAG_W-1] ? MAG_W'(-coord_ext) : unsigned'(coord_ext);
		phase_prod = PPROD_W'(mag) * PPROD_W'(lane_cfg.wavenumber);
	end

	// Fold the phase into the first quadrant; odd quadrants run backward.
	always_comb begin
		idx_scaled = SCALE_W'(phase_s1[13:0]) * SCALE_W'(SINE_TABLE_DEPTH);
		idx_raw    = idx_scaled[SCALE_W-1:14];
		idx        = phase_s1[14] ? IDX_W'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
	end

	always_comb begin
		depth_prod  = DPROD_W'(lane_cfg.depth) * DPROD_W'(sq_s3);
		depth_shift = depth_prod >>> 15;
		depth_mag   = lane_cfg.depth[COORD_W-1] ? MAG_W'(-MAG_W'(lane_cfg.depth))
			: MAG_W'(lane_cfg.depth);
		beyond_pot  = signed'(POT_W'(depth_mag) << 14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1  <= phase_prod[PHASE_W+7:8];
			inside_s1 <= mag < MAG_W'(lane_cfg.cutoff);
			sine_s2   <= SINE_ROM[idx];
			inside_s2 <= inside_s1;
			sq_s3     <= signed'(SQ_W'(sine_s2) * SQ_W'(sine_s2)) - SQ_HALF;
			inside_s3 <= inside_s2;
			pot_s4    <= inside_s3 ? POT_W'(depth_shift) : beyond_pot;
		end
	end

	assign pot = pot_s4;

endmodule

// ===== src/lpad_merge.sv =====
// Merge stage: sums the new and old lane potentials, scales the difference by
// time_scale and saturates to 48 bits over three stages. Depends on lpad_pkg.
module lpad_merge (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [lpad_pkg::POT_W-1:0] pot [lpad_pkg::LANES],
	input  logic [lpad_pkg::TS_W-1:0]         time_scale,
	output logic signed [lpad_pkg::ACT_W-1:0] delta
);
	import lpad_pkg::*;

	logic signed [DIFF_W-1:0] sum_new;
	logic signed [DIFF_W-1:0] sum_old;
	logic signed [SUM_W-1:0]  scaled;

	logic signed [DIFF_W-1:0] diff_s5;
	logic signed [PROD_W-1:0] phi_s6;
	logic signed [PROD_W-1:0] plo_s6;
	logic signed [ACT_W-1:0]  delta_s7;

	always_comb begin
		sum_new = '0;
		sum_old = '0;
		for (int a = 0; a < AXES; a++) begin
			sum_new = sum_new + DIFF_W'(pot[a]);
			sum_old = sum_old + DIFF_W'(pot[AXES+a]);
		end
	end

	// Integer part counts twice, since the fraction is taken to 2^-15.
	assign scaled = (SUM_W'(phi_s6) <<< 1) + SUM_W'(plo_s6 >>> 15);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s5  <= sum_new - sum_old;
			phi_s6   <= PROD_W'(diff_s5) * signed'(PROD_W'(time_scale[TS_W-1:16]));
			plo_s6   <= PROD_W'(diff_s5) * signed'(PROD_W'(time_scale[15:0]));
			delta_s7 <= sat_act(scaled);
		end
	end

	assign delta = delta_s7;

endmodule

// ===== src/lattice_potential_action_delta.sv =====
// Top level of the lattice potential action delta block: register file, lanes,
// merge, accumulator and output register. Depends on lpad_pkg, lpad_if,
// lpad_lane and lpad_merge.
//
// Accepts one bead pair per clock unless stalled and returns its pair delta and
// running total. The six coordinate lanes and the merge stages form one
// seven-stage pipeline that advances whenever the output register is empty or
// being taken; a stalled output stalls intake. The running total is the only
// value carried from item to item, updated as a result enters the output
// register, and cleared after an item marked final. Register writes are taken
// every cycle and must be made only while no item is in flight.
module lattice_potential_action_delta (
	input  logic        clk,
	input  logic        arst_n,
	lpad_in_if.sink     bead,
	lpad_out_if.source  action,
	lpad_cfg_if.sink    cfg
);
	import lpad_pkg::*;

	localparam int PIPE_STAGES = 7;

	logic [CFG_DATA_W-1:0] depths_q;
	logic [CFG_DATA_W-1:0] wavenumbers_q;
	logic [CFG_DATA_W-1:0] cutoffs_q;
	logic [TS_W-1:0]       time_scale_q;

	logic [PIPE_STAGES-1:0] pipe_vld_q;
	logic [PIPE_STAGES-1:0] pipe_last_q;
	logic                   out_vld_q;
	logic signed [ACT_W-1:0] acc_q;
	logic signed [ACT_W-1:0] delta_q;
	logic signed [ACT_W-1:0] total_q;
	logic                    last_q;

	logic                    adv;
	logic signed [COORD_W-1:0] new_c [3];
	logic signed [COORD_W-1:0] old_c [3];
	logic signed [POT_W-1:0]   pot [LANES];
	logic signed [ACT_W-1:0]   delta;
	logic signed [ACT_W-1:0]   total_next;

	assign adv = !out_vld_q || action.ready;
	assign bead.ready = adv;
	assign cfg.ready  = 1'b1;

	assign new_c[0] = bead.new_x;
	assign new_c[1] = bead.new_y;
	assign new_c[2] = bead.new_z;
	assign old_c[0] = bead.old_x;
	assign old_c[1] = bead.old_y;
	assign old_c[2] = bead.old_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depths_q      <= '0;
			wavenumbers_q <= '0;
			cutoffs_q     <= '0;
			time_scale_q  <= TIME_SCALE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_AXIS_DEPTHS:      depths_q      <= cfg.data;
				REG_AXIS_WAVENUMBERS: wavenumbers_q <= cfg.data;
				REG_AXIS_CUTOFFS:     cutoffs_q     <= cfg.data;
				REG_TIME_SCALE:       time_scale_q  <= cfg.data[TS_W-1:0];
				default: ;
			endcase
		end
	end

	// Lanes below AXES take new coordinates, the rest the old ones.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		localparam int AX = l % AXES;
		lane_cfg_t lane_cfg;

		assign lane_cfg = '{
			depth:      signed'(depths_q[COORD_W*AX +: COORD_W]),
			wavenumber: wavenumbers_q[COORD_W*AX +: COORD_W],
			cutoff:     cutoffs_q[COORD_W*AX +: COORD_W]
		};

		lpad_lane u_lane (
			.clk      (clk),
			.en       (adv),
			.lane_cfg (lane_cfg),
			.coord    ((l >= AXES) ? old_c[AX] : new_c[AX]),
			.pot      (pot[l])
		);
	end

	lpad_merge u_merge (
		.clk        (clk),
		.en         (adv),
		.pot        (pot),
		.time_scale (time_scale_q),
		.delta      (delta)
	);

	assign total_next = sat_act(SUM_W'(acc_q) + SUM_W'(delta));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
			out_vld_q  <= 1'b0;
			acc_q      <= '0;
		end else begin
			if (adv) begin
				pipe_vld_q <= {pipe_vld_q[PIPE_STAGES-2:0], bead.valid};
			end
			if (adv && pipe_vld_q[PIPE_STAGES-1]) begin
				out_vld_q <= 1'b1;
				acc_q     <= pipe_last_q[PIPE_STAGES-1] ? '0 : total_next;
			end else if (action.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_last_q <= {pipe_last_q[PIPE_STAGES-2:0], bead.final_pair};
			if (pipe_vld_q[PIPE_STAGES-1]) begin
				delta_q <= delta;
				total_q <= total_next;
				last_q  <= pipe_last_q[PIPE_STAGES-1];
			end
		end
	end

	assign action.valid         = out_vld_q;
	assign action.pair_delta    = delta_q;
	assign action.running_total = total_q;
	assign action.is_last       = last_q;

endmodule

// ===== src/lpad_checker.sv =====
// Port-level checks for lattice_potential_action_delta, attached by bind.
// Depends on lpad_pkg and the top level's channel interfaces.
module lpad_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [lpad_pkg::ACT_W-1:0] pair_delta,
	input logic signed [lpad_pkg::ACT_W-1:0] running_total,
	input logic                              is_last
);
	import lpad_pkg::*;

	// Whether the total started from zero at the next result.
	logic cleared_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cleared_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			cleared_q <= is_last;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_delta)
			&& $stable(running_total) && $stable(is_last))
		else $error("result beat changed while stalled");

	a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("bead accepted while result stalled");

	a_empty_takes_beads: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("intake blocked with empty output");

	a_total_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cleared_q |-> running_total == pair_delta)
		else $error("running total did not restart from zero");

	// A waiting bead beat stays offered until taken.
	a_bead_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("bead beat withdrawn before acceptance");

endmodule

bind lattice_potential_action_delta lpad_checker u_lpad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (bead.valid),
	.in_ready      (bead.ready),
	.out_valid     (action.valid),
	.out_ready     (action.ready),
	.pair_delta    (action.pair_delta),
	.running_total (action.running_total),
	.is_last       (action.is_last)
);
